FILE: rtl/skl_pkg.sv
// Shared types and constants for the sorted key lookup block.
// Item structs, opcodes, register indexes and controller/datapath links.
// No dependencies.
`default_nettype none

package skl_pkg;

	// table and field sizes
	localparam int DEFAULT_TABLE_DEPTH = 1024;
	localparam int KEY_W               = 64;
	localparam int COUNT_W             = 11;
	localparam int INDEX_W             = 10;
	localparam int CFG_INDEX_W         = 1;
	localparam int CFG_DATA_W          = 64;

	// item opcodes
	typedef enum logic [0:0] {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} opcode_t;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_VALUE = 1'd1;

	// input item
	typedef struct packed {
		opcode_t            opcode;
		logic [INDEX_W-1:0] entry_index;
		logic [KEY_W-1:0]   entry_key;
		logic [KEY_W-1:0]   entry_value;
		logic [KEY_W-1:0]   lookup_key;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [COUNT_W-1:0] position;
		logic               found;
		logic [KEY_W-1:0]   result_value;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic write;
		logic start;
		logic step;
		logic finish;
	} skl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic span_zero;
		logic out_free;
	} skl_status_t;

endpackage

`default_nettype wire

FILE: rtl/skl_ctrl.sv
// Controller for the sorted key lookup: accepts items and sequences the search.
// Depends on skl_pkg.
`default_nettype none

module skl_ctrl
	import skl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire opcode_t     in_opcode,
	input  wire skl_status_t status,
	output logic             busy,
	output skl_cmd_t         cmd
);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   take;

	// item taken only while idle
	assign take = in_valid && !busy_q;

	// command decode
	always_comb begin
		cmd.write  = take && (in_opcode == OP_WRITE);
		cmd.start  = take && (in_opcode == OP_LOOKUP);
		cmd.step   = (state_q == ST_SEARCH) && !status.span_zero;
		cmd.finish = (state_q == ST_SEARCH) && status.span_zero && status.out_free;
	end

	assign busy = busy_q;

	// state and registered busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_SEARCH;
						busy_q  <= 1'b1;
					end
				end
				ST_SEARCH: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/skl_datapath.sv
// Datapath for the sorted key lookup: key/value memories, search registers,
// configuration registers and the result register. Depends on skl_pkg.
`default_nettype none

module skl_datapath
	import skl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire skl_cmd_t               cmd,
	output skl_status_t                 status,
	input  wire in_item_t               in_item,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output out_item_t                   out_item
);

	localparam int          AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

	// key and value memories
	logic [KEY_W-1:0] key_mem   [TABLE_DEPTH];
	logic [KEY_W-1:0] value_mem [TABLE_DEPTH];

	logic [COUNT_W-1:0] entry_count_q;
	logic [KEY_W-1:0]   default_value_q;
	logic [COUNT_W-1:0] count_sat;

	logic [COUNT_W-1:0] base_q, span_q, base_d, span_d, half, probe, rd_full;
	logic [KEY_W-1:0]   key_q;
	logic [KEY_W-1:0]   rd_key_q, rd_val_q;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic               wr_en;
	logic               found;

	out_item_t out_q;
	logic      out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q   <= '0;
			default_value_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ENTRY_COUNT:   entry_count_q   <= cfg_data[COUNT_W-1:0];
				REG_DEFAULT_VALUE: default_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// count limited to the table depth
	assign count_sat = ({{(32-COUNT_W){1'b0}}, entry_count_q} > DEPTH32)
		? COUNT_W'(TABLE_DEPTH) : entry_count_q;

	// next search window, one probe per cycle
	always_comb begin
		half   = span_q >> 1;
		probe  = base_q + half;
		base_d = base_q;
		span_d = span_q;
		if (cmd.start) begin
			base_d = '0;
			span_d = count_sat;
		end else if (cmd.step) begin
			if (rd_key_q < key_q) begin
				base_d = probe + COUNT_W'(1);
				span_d = span_q - half - COUNT_W'(1);
			end else begin
				span_d = half;
			end
		end
		rd_full = (span_d != '0) ? (base_d + (span_d >> 1)) : base_d;
	end

	assign rd_addr = AW'(rd_full);
	assign wr_addr = AW'(in_item.entry_index);
	assign wr_en   = cmd.write
		&& ({{(32-INDEX_W){1'b0}}, in_item.entry_index} < DEPTH32);

	// search registers
	always_ff @(posedge clk) begin
		base_q <= base_d;
		span_q <= span_d;
		if (cmd.start) begin
			key_q <= in_item.lookup_key;
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]   <= in_item.entry_key;
			value_mem[wr_addr] <= in_item.entry_value;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_val_q <= value_mem[rd_addr];
	end

	// match at the final position
	assign found = (base_q < count_sat) && (rd_key_q == key_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.position     <= base_q;
			out_q.found        <= found;
			out_q.result_value <= found ? rd_val_q : default_value_q;
		end
	end

	assign status.span_zero = (span_q == '0);
	assign status.out_free  = !out_valid_q || !out_stall;
	assign out_valid        = out_valid_q;
	assign out_item         = out_q;

endmodule

`default_nettype wire

FILE: rtl/sorted_key_lookup_with_default.sv
// Lower-bound lookup over a table of ascending 64-bit keys with paired values.
// A write item stores one entry and gives no result. A lookup item is accepted,
// probes the key memory (separate write and read ports) once per binary-search
// step and then loads the result register. Only one lookup is in flight;
// a finished result may wait in the output register while the next item is
// taken. Keys or values of entries never written read as undefined.
// Depends on skl_pkg, skl_ctrl and skl_datapath.
`default_nettype none

module sorted_key_lookup_with_default
	import skl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire in_item_t               in_item,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output out_item_t                   out_item
);

	skl_cmd_t    cmd;
	skl_status_t status;

	// sequencer
	skl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_item.opcode),
		.status    (status),
		.busy      (in_stall),
		.cmd       (cmd)
	);

	// memories, search and result registers
	skl_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_item   (in_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

FILE: test/tb_sorted_key_lookup_with_default.sv
// Testbench for sorted_key_lookup_with_default: fills key/value tables, runs lookups
// and checks every result against a lower-bound search model kept in the bench.
// Depends on skl_pkg and the sorted_key_lookup_with_default RTL.

module tb_sorted_key_lookup_with_default;
	import skl_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam int IW = $clog2(DEPTH);
	localparam int RANDOM_ITEMS = 120;
	localparam int SETTLE_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;

	// mirror of the table and registers
	logic [KEY_W-1:0] key_mirror [DEPTH];
	logic [KEY_W-1:0] value_mirror [DEPTH];
	logic [COUNT_W-1:0] count_mirror = '0;
	logic [KEY_W-1:0] default_mirror = '0;

	out_item_t pending_results [$];
	out_item_t want;
	int errors = 0;
	int idle_cycles = 0;
	int stall_run = 0;
	bit no_gaps = 1'b0;

	sorted_key_lookup_with_default #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	always #4 clk = ~clk;

	// lower-bound search over the active entries, default on a miss
	function automatic out_item_t predict_lower_bound(logic [KEY_W-1:0] key);
		int unsigned n, base, span, half, probe;
		out_item_t r;
		n = (count_mirror > DEPTH) ? DEPTH : count_mirror;
		base = 0;
		span = n;
		while (span != 0) begin
			half = span >> 1;
			probe = base + half;
			if (key_mirror[IW'(probe)] < key) begin
				base = probe + 1;
				span -= half + 1;
			end else begin
				span = half;
			end
		end
		r.position = base[COUNT_W-1:0];
		r.found = 1'b0;
		r.result_value = default_mirror;
		if (base < n) begin
			if (key_mirror[IW'(base)] == key) begin
				r.found = 1'b1;
				r.result_value = value_mirror[IW'(base)];
			end
		end
		return r;
	endfunction

	// write item; the unused lookup key carries noise
	function automatic in_item_t make_write(int unsigned idx, logic [KEY_W-1:0] key,
			logic [KEY_W-1:0] value);
		in_item_t it;
		it.opcode = OP_WRITE;
		it.entry_index = idx[INDEX_W-1:0];
		it.entry_key = key;
		it.entry_value = value;
		it.lookup_key = {$urandom, $urandom};
		return it;
	endfunction

	// lookup item; the unused entry fields carry noise
	function automatic in_item_t make_lookup(logic [KEY_W-1:0] key);
		in_item_t it;
		it.opcode = OP_LOOKUP;
		it.entry_index = INDEX_W'($urandom_range(0, DEPTH - 1));
		it.entry_key = {$urandom, $urandom};
		it.entry_value = {$urandom, $urandom};
		it.lookup_key = key;
		return it;
	endfunction

	// sender gap: mostly none or short, a few long
	function automatic int pick_gap();
		int unsigned r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// next ascending key, with duplicates and saturation at the top
	function automatic logic [KEY_W-1:0] step_key(logic [KEY_W-1:0] prev);
		logic [KEY_W:0] sum;
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			sum = {1'b0, prev};
		else if (r < 5)
			sum = {1'b0, prev} + {33'b0, $urandom_range(1, 16)};
		else
			sum = {1'b0, prev} + {33'b0, $urandom};
		return sum[KEY_W] ? '1 : sum[KEY_W-1:0];
	endfunction

	function automatic logic [KEY_W-1:0] pick_base_key();
		int unsigned r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return '0;
		else if (r == 1)
			return {32'b0, $urandom};
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] pick_default();
		int unsigned r;
		r = $urandom_range(0, 5);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// lookup key: mostly present keys and their neighbors, some extremes and noise
	function automatic logic [KEY_W-1:0] pick_lookup_key(int unsigned n);
		logic [KEY_W-1:0] k;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (n != 0 && sel < 50) begin
			k = key_mirror[IW'($urandom_range(0, n - 1))];
		end else if (n != 0 && sel < 70) begin
			k = key_mirror[IW'($urandom_range(0, n - 1))];
			k = $urandom_range(0, 1) ? k + 64'd1 : k - 64'd1;
		end else if (sel < 80) begin
			k = $urandom_range(0, 1) ? '0 : '1;
		end else begin
			k = {$urandom, $urandom};
		end
		return k;
	endfunction

	// send one item and update the model once it is accepted
	task automatic send_item(input in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.opcode == OP_WRITE) begin
			key_mirror[it.entry_index] = it.entry_key;
			value_mirror[it.entry_index] = it.entry_value;
		end else begin
			pending_results.push_back(predict_lower_bound(it.lookup_key));
		end
	endtask

	// drain all results, then let any write item finish
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_ENTRY_COUNT)
			count_mirror = data[COUNT_W-1:0];
		else
			default_mirror = data;
	endtask

	task automatic set_config(input int unsigned count, input logic [KEY_W-1:0] dflt);
		write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(count));
		write_reg(REG_DEFAULT_VALUE, dflt);
	endtask

	// fill entries 0..n-1 with ascending keys and random values
	task automatic fill_ascending(input int unsigned n);
		logic [KEY_W-1:0] key;
		int unsigned i;
		key = pick_base_key();
		for (i = 0; i < n; i++) begin
			if (i != 0)
				key = step_key(key);
			send_item(make_write(i, key, {$urandom, $urandom}));
		end
	endtask

	// empty table straight after reset: no entry can match, default comes back
	task automatic test_empty_table();
		send_item(make_lookup('0));
		send_item(make_lookup('1));
		wait_idle();
	endtask

	// extreme and duplicate keys, key above all entries
	task automatic test_extreme_keys();
		set_config(4, '1);
		send_item(make_write(0, '0, {$urandom, $urandom}));
		send_item(make_write(1, 64'd5, '1));
		send_item(make_write(2, 64'd5, '0));
		send_item(make_write(3, '1, {$urandom, $urandom}));
		send_item(make_lookup('0));
		send_item(make_lookup(64'd3));
		send_item(make_lookup(64'd5));
		send_item(make_lookup(64'd6));
		send_item(make_lookup('1));
		wait_idle();
		set_config(3, '0);
		send_item(make_lookup('1));
		send_item(make_lookup(64'd5));
		wait_idle();
	endtask

	// keys out of order: whatever the halving search gives
	task automatic test_unsorted_keys();
		set_config(4, {$urandom, $urandom});
		send_item(make_write(0, 64'd9, {$urandom, $urandom}));
		send_item(make_write(1, 64'd2, {$urandom, $urandom}));
		send_item(make_write(2, 64'd7, {$urandom, $urandom}));
		send_item(make_write(3, 64'd1, {$urandom, $urandom}));
		send_item(make_lookup(64'd1));
		send_item(make_lookup(64'd2));
		send_item(make_lookup(64'd7));
		send_item(make_lookup(64'd9));
		send_item(make_lookup(64'd0));
		wait_idle();
	endtask

	// whole table in use, then counts past the table that must saturate
	task automatic test_full_table();
		int unsigned i;
		set_config(DEPTH, pick_default());
		fill_ascending(DEPTH);
		for (i = 0; i < 100; i++)
			send_item(make_lookup(pick_lookup_key(DEPTH)));
		wait_idle();
		set_config(2047, pick_default());
		for (i = 0; i < 50; i++)
			send_item(make_lookup(pick_lookup_key(DEPTH)));
		wait_idle();
		set_config(DEPTH + 1, pick_default());
		for (i = 0; i < 20; i++)
			send_item(make_lookup(pick_lookup_key(DEPTH)));
		wait_idle();
	endtask

	// many small random tables with lookups and some out-of-order rewrites
	task automatic test_random_tables();
		int unsigned sent, n, m, i, r;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			n = (r < 8) ? 0 : (r < 16) ? 1 : $urandom_range(2, 48);
			set_config(n, pick_default());
			fill_ascending(n);
			m = $urandom_range(4, 2 * n + 8);
			for (i = 0; i < m; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_item(make_write($urandom_range(0, DEPTH - 1), {$urandom, $urandom},
						{$urandom, $urandom}));
				else
					send_item(make_lookup(pick_lookup_key(n)));
			end
			sent += n + m;
			wait_idle();
		end
		no_gaps = 1'b0;
	endtask

	// receiver stall: runs of stall and of no stall, mostly short
	always @(posedge clk) begin
		if (stall_run == 0) begin
			if ($urandom_range(0, 99) < 30) begin
				out_stall <= 1'b1;
				stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
			end else begin
				out_stall <= 1'b0;
				stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
					: $urandom_range(1, 8);
			end
		end else begin
			stall_run <= stall_run - 1;
		end
	end

	// compare each result item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %p", $time, out_item);
			end else begin
				want = pending_results.pop_front();
				if (out_item.position !== want.position) begin
					errors++;
					$display("%0t: position expected %0d got %0d", $time,
						want.position, out_item.position);
				end
				if (out_item.found !== want.found) begin
					errors++;
					$display("%0t: found expected %0b got %0b", $time, want.found, out_item.found);
				end
				if (out_item.result_value !== want.result_value) begin
					errors++;
					$display("%0t: result_value expected %h got %h", $time,
						want.result_value, out_item.result_value);
				end
			end
		end
	end

	// watchdog on cycles with no item moving either way
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_extreme_keys();
		test_unsorted_keys();
		test_random_tables();
		test_full_table();
		wait_idle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/skl_pkg.sv
rtl/skl_ctrl.sv
rtl/skl_datapath.sv
rtl/sorted_key_lookup_with_default.sv
test/tb_sorted_key_lookup_with_default.sv
